// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/eafp_pkg.sv -----
// ----------------------------------------------------------------------------
// eafp_pkg
// Types and constants for the ADC status frame parser.
// ----------------------------------------------------------------------------
package eafp_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int CHAN_W           = 3;
  localparam int PHASE_W          = 2;

  // Byte phase inside a three byte group
  localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PH_THIRD  = 2'd2;

  localparam logic [3:0] NIBBLE_MASK = 4'h0F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic               is_status;
    logic [2:0]         channel_index;
    logic signed [23:0] channel_value;
    logic [23:0]        status_word;
    logic [3:0]         lead_off_p;
    logic [3:0]         lead_off_n;
    logic [3:0]         gpio_bits;
    logic [31:0]        frame_number;
    logic               last_in_frame;
  } result_t;

  // Where the current byte sits in the frame
  typedef struct packed {
    logic               in_status;
    logic [PHASE_W-1:0] phase;
    logic [CHAN_W-1:0]  chan;
    logic               last_chan;
  } pos_t;

endpackage

// ----- sv/eeg_adc_frame_parser.sv -----
// ----------------------------------------------------------------------------
// eeg_adc_frame_parser
// Splits a byte stream of converter frames into status and channel results.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, every cycle, while the result register is free
// or being drained; a result appears in the cycle after the third byte of the
// status header or of a channel group, and the single result register holds
// it against back-pressure. A frame is three status bytes then three
// big-endian bytes per channel for NUM_CHANNELS channels (1 to 8). Setting
// frame_start on a byte makes it the first status byte and drops any partial
// frame; without it the position wraps after the last channel byte.
// frame_number counts status headers since reset, wrapping at 32 bits, and
// channel results carry the count of their frame.
module eeg_adc_frame_parser #(
  parameter int NUM_CHANNELS = eafp_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  eafp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output eafp_pkg::result_t result
);
  import eafp_pkg::*;

  pos_t        pos;
  logic        accept;
  logic        group_done;
  logic [15:0] byte_gather;
  logic [31:0] frame_count;
  logic [31:0] frame_count_next;
  logic [23:0] word;
  result_t     result_next;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  eafp_framer #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .frame_start(item.frame_start),
    .pos        (pos)
  );

  assign group_done       = (pos.phase == PH_THIRD);
  assign word             = {byte_gather, item.data_byte};
  assign frame_count_next = (group_done && pos.in_status) ? frame_count + 32'd1
                                                          : frame_count;

  always_comb begin
    result_next              = '0;
    result_next.is_status    = pos.in_status;
    result_next.frame_number = frame_count_next;
    if (pos.in_status) begin
      result_next.status_word = word;
      result_next.lead_off_p  = byte_gather[7:4];
      result_next.lead_off_n  = byte_gather[3:0] & NIBBLE_MASK;
      result_next.gpio_bits   = item.data_byte[3:0] & NIBBLE_MASK;
    end else begin
      result_next.channel_index = pos.chan;
      result_next.channel_value = signed'(word);
      result_next.last_in_frame = pos.last_chan;
    end
  end

  // Shift each byte in; the first byte of a group lands above the second
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather <= '0;
      frame_count <= '0;
    end else if (accept) begin
      byte_gather <= {byte_gather[7:0], item.data_byte};
      frame_count <= frame_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_ready) begin
      result_valid <= accept && group_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && group_done) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/eafp_framer.sv -----
// ----------------------------------------------------------------------------
// eafp_framer
// Tracks the position of each byte: status or channel group, byte phase
// within the group, and channel number. frame_start forces the first byte.
// ----------------------------------------------------------------------------
module eafp_framer #(
  parameter int NUM_CHANNELS = eafp_pkg::NUM_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          frame_start,
  output eafp_pkg::pos_t pos
);
  import eafp_pkg::*;

  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS - 1);

  logic               in_status;
  logic [PHASE_W-1:0] phase;
  logic [CHAN_W-1:0]  chan;

  logic               in_status_next;
  logic [PHASE_W-1:0] phase_next;
  logic [CHAN_W-1:0]  chan_next;

  // A marked byte is the first status byte whatever came before
  always_comb begin
    if (frame_start) begin
      pos.in_status = 1'b1;
      pos.phase     = PH_FIRST;
      pos.chan      = '0;
    end else begin
      pos.in_status = in_status;
      pos.phase     = phase;
      pos.chan      = chan;
    end
    pos.last_chan = !pos.in_status && (pos.chan == LAST_CHAN);
  end

  always_comb begin
    in_status_next = pos.in_status;
    chan_next      = pos.chan;
    phase_next     = pos.phase + PHASE_W'(1);
    if (pos.phase == PH_THIRD) begin
      phase_next = PH_FIRST;
      if (pos.in_status) begin
        in_status_next = 1'b0;
        chan_next      = '0;
      end else if (pos.last_chan) begin
        // wrap to the next frame's status bytes
        in_status_next = 1'b1;
        chan_next      = '0;
      end else begin
        chan_next = pos.chan + CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_status <= 1'b1;
      phase     <= PH_FIRST;
      chan      <= '0;
    end else if (advance) begin
      in_status <= in_status_next;
      phase     <= phase_next;
      chan      <= chan_next;
    end
  end

endmodule

// ----- sv/eafp_checker.sv -----
// ----------------------------------------------------------------------------
// eafp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eafp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input eafp_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input eafp_pkg::result_t result
);
  import eafp_pkg::*;

  logic status_ok;
  logic channel_ok;

  assign status_ok = result.channel_index == 3'd0 && result.channel_value == 24'sd0 &&
                     !result.last_in_frame &&
                     result.lead_off_p == result.status_word[15:12] &&
                     result.lead_off_n == result.status_word[11:8] &&
                     result.gpio_bits == result.status_word[3:0];

  assign channel_ok = result.status_word == 24'd0 && result.lead_off_p == 4'd0 &&
                      result.lead_off_n == 4'd0 && result.gpio_bits == 4'd0;

  // A stalled result beat holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  // An empty result register never blocks input
  `ASSERT_IMPL(a_ready_when_free, clk, rst, !result_valid, item_ready, "input stalled with free result register")

  `ASSERT_IMPL(a_status_fields, clk, rst, result_valid && result.is_status, status_ok, "status result fields inconsistent")

  `ASSERT_IMPL(a_channel_fields, clk, rst, result_valid && !result.is_status, channel_ok, "channel result carries status fields")

endmodule

bind eeg_adc_frame_parser eafp_checker u_eafp_checker (.*);

// ----- bench/frame_parser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_parser_checker
// Watches both channels of the frame parser, predicts the status and channel
// results from each accepted byte, and compares every result beat field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_parser_checker #(
  parameter int NUM_CH = eafp_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  eafp_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  eafp_pkg::result_t result,
  output int                fail_count,
  output int                pending_count
);
  import eafp_pkg::*;

  localparam int HDR_LEN   = 3;
  localparam int FRAME_LEN = HDR_LEN + 3 * NUM_CH;

  // Parser state as the block should hold it
  int          byte_pos;
  logic [15:0] gather;
  logic [31:0] frame_cnt;

  result_t awaited_results[$];
  int      mismatches = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic parse_frame_byte(input item_t it);
    int                 p;
    int                 chan;
    logic [PHASE_W-1:0] ph;
    logic [23:0]        word;
    result_t            r;
    p = (it.frame_start || byte_pos >= FRAME_LEN) ? 0 : byte_pos;
    ph = (p < HDR_LEN) ? PHASE_W'(p) : PHASE_W'((p - HDR_LEN) % 3);
    case (ph)
      PH_FIRST: begin
        gather = {8'h00, it.data_byte};
      end
      PH_SECOND: begin
        gather = {gather[7:0], it.data_byte};
      end
      default: begin
        word   = {gather, it.data_byte};
        gather = '0;
        r      = '0;
        if (p < HDR_LEN) begin
          // Count the frame before reporting it
          frame_cnt      = frame_cnt + 32'd1;
          r.is_status    = 1'b1;
          r.status_word  = word;
          r.lead_off_p   = word[15:12];
          r.lead_off_n   = word[11:8] & NIBBLE_MASK;
          r.gpio_bits    = it.data_byte[3:0] & NIBBLE_MASK;
          r.frame_number = frame_cnt;
        end else begin
          chan            = (p - HDR_LEN) / 3;
          r.channel_index = chan[2:0];
          r.channel_value = word;
          r.frame_number  = frame_cnt;
          r.last_in_frame = (chan == NUM_CH - 1);
        end
        awaited_results.push_back(r);
      end
    endcase
    p = p + 1;
    byte_pos = (p >= FRAME_LEN) ? 0 : p;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      byte_pos  = 0;
      gather    = '0;
      frame_cnt = '0;
      awaited_results.delete();
    end else begin
      if (item_valid && item_ready)
        parse_frame_byte(item);
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %p", $time, result);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("is_status", 32'(want.is_status), 32'(result.is_status));
          compare_field("channel_index", 32'(want.channel_index),
                        32'(result.channel_index));
          compare_field("channel_value", 32'(want.channel_value),
                        32'(result.channel_value));
          compare_field("status_word", 32'(want.status_word), 32'(result.status_word));
          compare_field("lead_off_p", 32'(want.lead_off_p), 32'(result.lead_off_p));
          compare_field("lead_off_n", 32'(want.lead_off_n), 32'(result.lead_off_n));
          compare_field("gpio_bits", 32'(want.gpio_bits), 32'(result.gpio_bits));
          compare_field("frame_number", want.frame_number, result.frame_number);
          compare_field("last_in_frame", 32'(want.last_in_frame),
                        32'(result.last_in_frame));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= awaited_results.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives converter frames into the frame parser: a directed frame with
// extreme values and a resync, then random whole frames, cut-off frames and
// stray bytes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import eafp_pkg::*;

  localparam int FRAME_BYTES  = 3 + 3 * NUM_CHANNELS_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 250;
  localparam int IDLE_LIMIT   = 2000;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int fail_count;
  int pending_count;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit send_burst  = 1'b0;

  always #6 clk = ~clk;

  eeg_adc_frame_parser uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  frame_parser_checker #(.NUM_CH(NUM_CHANNELS_DEF)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Offer one byte after a random gap and hold it until the beat
  task automatic send_byte(input logic [7:0] data, input logic start);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 39) == 0)
      send_burst = !send_burst;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: data, frame_start: start};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_channel(input logic [23:0] value);
    send_byte(value[23:16], 1'b0);
    send_byte(value[15:8], 1'b0);
    send_byte(value[7:0], 1'b0);
  endtask

  // Receiver: random stalls, one long hold-off to back the block up
  initial begin
    int gap;
    int seen;
    bit burst;
    seen  = 0;
    burst = 1'b0;
    forever begin
      if (seen == HOLD_AT) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = burst ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 29) == 0)
        burst = !burst;
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int kind;
    int len;
    int stop_at;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frame: extreme status bytes and channel values
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5F, 1'b0);
    send_channel(24'h800000);
    send_channel(24'h7FFFFF);
    send_channel(24'hFFFFFF);
    send_channel(24'h000000);
    send_channel(24'h000001);
    send_channel(24'h123456);
    send_channel(24'hFEDCBA);
    send_channel(24'h5A5A5A);
    // Partial header, followed by the random traffic below
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);

    stop_at = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Whole frame; an unmarked one relies on the position wrap
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
        repeat (FRAME_BYTES - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 9) begin
        len = $urandom_range(1, FRAME_BYTES - 1);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (len - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_count != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_count);
    if (fail_count == 0 && pending_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/eafp_pkg.sv
sv/eafp_framer.sv
sv/eeg_adc_frame_parser.sv
sv/eafp_checker.sv
bench/frame_parser_checker.sv
bench/testbench.sv
